// ===== rtl/aid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_pkg
// Shared types and constants of the station identifier allocator.
// ----------------------------------------------------------------------------
package aid_pkg;

  // Identifier and bitmap geometry
  localparam int unsigned ID_W        = 11;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned BIT_W       = 5;             // log2(WORD_BITS)
  localparam int unsigned WIDX_W      = ID_W - BIT_W;  // word index of an id

  // Defaults for the top-level parameters
  localparam int unsigned MAX_ID_DEF       = 2007;
  localparam int unsigned BITMAP_WORDS_DEF = 63;

  // Request kinds (carried in tuser)
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Update of the per-word full flags
  typedef struct packed {
    logic              wr;
    logic [WIDX_W-1:0] idx;
    logic              full;
  } full_upd_t;

endpackage

// ===== rtl/aid_bitmap_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_bitmap_ram
// Bitmap word store: one write and one read port, read data registered.
// A word never written since reset reads as zero (all identifiers free).
// ----------------------------------------------------------------------------
module aid_bitmap_ram #(
  parameter int unsigned BITMAP_WORDS = aid_pkg::BITMAP_WORDS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [aid_pkg::WIDX_W-1:0] rd_idx_i,
  output logic [aid_pkg::WORD_BITS-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [aid_pkg::WIDX_W-1:0] wr_idx_i,
  input  logic [aid_pkg::WORD_BITS-1:0] wr_data_i
);

  logic [aid_pkg::WORD_BITS-1:0] mem_q [BITMAP_WORDS];
  logic [BITMAP_WORDS-1:0]       written_q;
  logic [aid_pkg::WORD_BITS-1:0] rd_data_q;
  logic                          rd_written_q;

  // Storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  // Written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

// ===== rtl/aid_word_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_word_tracker
// One full flag per bitmap word; finds the lowest word with a free bit.
// ----------------------------------------------------------------------------
module aid_word_tracker #(
  parameter int unsigned BITMAP_WORDS = aid_pkg::BITMAP_WORDS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  aid_pkg::full_upd_t         upd_i,
  output logic                       any_free_o,
  output logic [aid_pkg::WIDX_W-1:0] free_idx_o
);

  logic [BITMAP_WORDS-1:0] full_q;

  // Full flags, all clear at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
    end else if (upd_i.wr) begin
      full_q[upd_i.idx] <= upd_i.full;
    end
  end

  // Lowest word that is not full
  always_comb begin
    free_idx_o = '0;
    for (int i = BITMAP_WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        free_idx_o = aid_pkg::WIDX_W'(i);
      end
    end
  end

  assign any_free_o = ~&full_q;

endmodule

// ===== rtl/association_id_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// association_id_allocator_top
// Station identifier allocator on a bitmap memory.
// ----------------------------------------------------------------------------
// Identifiers 1..MAX_ID are kept one bit each in a memory of BITMAP_WORDS
// 32-bit words, all free after reset (no clearing pass is needed). An
// allocate request (tuser 0) grants the lowest free identifier with ok set,
// or 0 with ok clear if none at or below MAX_ID is free. A release request
// (tuser 1) frees the identifier in tdata; an identifier of 0, above MAX_ID
// or beyond the map answers ok clear and changes nothing. Each request gives
// exactly one result. Between one acceptance and the next a request goes
// through word select from the full flags, one memory read, the bit search
// with write-back, and the move into the output register. A rejected
// release, or an allocate when every word is full, skips the memory read.
// A result held by a stalled master side delays the next request.
// ----------------------------------------------------------------------------
module association_id_allocator_top #(
  parameter int unsigned MAX_ID       = aid_pkg::MAX_ID_DEF,
  parameter int unsigned BITMAP_WORDS = aid_pkg::BITMAP_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [10:0] release_id
  input  logic [0:0]  s_axis_tuser,   // [0] req_type
  // Result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [10:0] granted_id
  output logic [0:0]  m_axis_tuser    // [0] ok
);

  localparam int unsigned ID_W   = aid_pkg::ID_W;
  localparam int unsigned BIT_W  = aid_pkg::BIT_W;
  localparam int unsigned WIDX_W = aid_pkg::WIDX_W;

  localparam logic [ID_W:0]   MAX_ID_L = (ID_W + 1)'(MAX_ID);
  localparam logic [WIDX_W:0] WORDS_L  = (WIDX_W + 1)'(BITMAP_WORDS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic        req_q;
  logic [ID_W-1:0]   rel_id_q;
  logic [WIDX_W-1:0] widx_q, widx_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  logic        res_ok_q, res_ok_d;
  logic        m_valid_q;
  logic [ID_W-1:0]   m_id_q;
  logic        m_ok_q;

  logic              rd_en;
  logic [aid_pkg::WORD_BITS-1:0] rd_word;
  logic              wr_en;
  logic [aid_pkg::WORD_BITS-1:0] wr_word;
  aid_pkg::full_upd_t upd;
  logic              any_free;
  logic [WIDX_W-1:0] free_idx;

  logic [ID_W-1:0]   rel_m1;
  logic [BIT_W-1:0]  low_clr;
  logic [ID_W:0]     alloc_id;
  logic              out_free;
  logic              s_fire;

  aid_bitmap_ram #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_idx_i  (widx_d),
    .rd_data_o (rd_word),
    .wr_en_i   (wr_en),
    .wr_idx_i  (widx_q),
    .wr_data_i (wr_word)
  );

  aid_word_tracker #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .any_free_o (any_free),
    .free_idx_o (free_idx)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign rel_m1        = rel_id_q - ID_W'(1);

  // Lowest clear bit of the word read back
  always_comb begin
    low_clr = '0;
    for (int i = aid_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_word[i]) begin
        low_clr = BIT_W'(i);
      end
    end
  end

  assign alloc_id = {1'b0, widx_q, low_clr} + (ID_W + 1)'(1);

  // Request sequencer
  always_comb begin
    state_d  = state_q;
    widx_d   = widx_q;
    bit_d    = bit_q;
    res_id_d = res_id_q;
    res_ok_d = res_ok_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_word  = rd_word;
    upd      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        res_id_d = '0;
        res_ok_d = 1'b0;
        if (req_q == aid_pkg::REQ_ALLOC) begin
          widx_d = free_idx;
          if (any_free) begin
            rd_en   = 1'b1;
            state_d = S_READ;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          widx_d = rel_m1[ID_W-1 -: WIDX_W];
          bit_d  = rel_m1[BIT_W-1:0];
          if ((rel_id_q != '0) && ({1'b0, rel_id_q} <= MAX_ID_L) &&
              ({1'b0, rel_m1[ID_W-1 -: WIDX_W]} < WORDS_L)) begin
            rd_en   = 1'b1;
            state_d = S_READ;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_READ: begin
        state_d  = S_OUT;
        upd.idx  = widx_q;
        if (req_q == aid_pkg::REQ_ALLOC) begin
          if (alloc_id <= MAX_ID_L) begin
            wr_en    = 1'b1;
            wr_word  = rd_word | (aid_pkg::WORD_BITS'(1) << low_clr);
            upd.wr   = 1'b1;
            upd.full = &wr_word;
            res_id_d = alloc_id[ID_W-1:0];
            res_ok_d = 1'b1;
          end
        end else begin
          wr_en    = 1'b1;
          wr_word  = rd_word & ~(aid_pkg::WORD_BITS'(1) << bit_q);
          upd.wr   = 1'b1;
          upd.full = 1'b0;
          res_ok_d = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_OUT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      req_q    <= s_axis_tuser[0];
      rel_id_q <= s_axis_tdata[ID_W-1:0];
    end
    widx_q   <= widx_d;
    bit_q    <= bit_d;
    res_id_q <= res_id_d;
    res_ok_q <= res_ok_d;
    if ((state_q == S_OUT) && out_free) begin
      m_id_q <= res_id_q;
      m_ok_q <= res_ok_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(16 - ID_W)'(0), m_id_q};
  assign m_axis_tuser  = m_ok_q;

endmodule

// ===== tb/sv/aid_grant_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_grant_checker
// Watches both stream sides of the identifier allocator and checks results.
// ----------------------------------------------------------------------------
// Every accepted request updates a shadow copy of the identifier bitmap and
// queues the result it must produce. Every accepted result is compared field
// by field with the oldest queued one. Failures and the number of results
// still outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------
module aid_grant_checker #(
  parameter int unsigned MAX_ID       = aid_pkg::MAX_ID_DEF,
  parameter int unsigned BITMAP_WORDS = aid_pkg::BITMAP_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [15:0] req_data_i,    // [10:0] release_id
  input  logic [0:0]  req_user_i,    // [0] req_type
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [15:0] res_data_i,    // [10:0] granted_id
  input  logic [0:0]  res_user_i,    // [0] ok
  output int          errors_o,
  output int          pending_o,
  output int          results_o,
  output int          grants_o,
  output int          denials_o,
  output int          rejects_o
);
  import aid_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            ok;
  } grant_t;

  logic [WORD_BITS-1:0] id_map [BITMAP_WORDS];
  grant_t               grants_due [$];

  assign pending_o = grants_due.size();

  // Lowest free identifier; granted only if it is within the maximum
  function automatic grant_t next_grant();
    grant_t      g;
    int unsigned id;
    g = '0;
    for (int w = 0; w < BITMAP_WORDS; w++) begin
      if (id_map[w] != '1) begin
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
          if (!id_map[w][b]) id = w * WORD_BITS + b + 1;
        end
        if (id <= MAX_ID) begin
          id_map[w][(id - 1) % WORD_BITS] = 1'b1;
          g.id = id[ID_W-1:0];
          g.ok = 1'b1;
          grants_o++;
        end else begin
          denials_o++;
        end
        return g;
      end
    end
    denials_o++;
    return g;
  endfunction

  // Release: out-of-range identifiers are rejected, a free one is harmless
  function automatic grant_t release_id(input logic [ID_W-1:0] id);
    grant_t      g;
    int unsigned w;
    g = '0;
    w = (int'(id) - 1) / WORD_BITS;
    if (id == 0 || id > MAX_ID || w >= BITMAP_WORDS) begin
      rejects_o++;
      return g;
    end
    id_map[w][(id - 1) % WORD_BITS] = 1'b0;
    g.ok = 1'b1;
    return g;
  endfunction

  function automatic void check_result();
    grant_t want;
    results_o++;
    if (grants_due.size() == 0) begin
      $error("result with nothing outstanding: granted_id %0d ok %0d",
             res_data_i[ID_W-1:0], res_user_i[0]);
      errors_o++;
      return;
    end
    want = grants_due.pop_front();
    if (res_data_i[ID_W-1:0] !== want.id) begin
      $error("granted_id mismatch: expected %0d, actual %0d",
             want.id, res_data_i[ID_W-1:0]);
      errors_o++;
    end
    if (res_user_i[0] !== want.ok) begin
      $error("ok mismatch: expected %0d, actual %0d", want.ok, res_user_i[0]);
      errors_o++;
    end
    if (res_data_i[15:ID_W] !== '0) begin
      $error("tdata padding mismatch: expected 0, actual %0h",
             res_data_i[15:ID_W]);
      errors_o++;
    end
  endfunction

  initial begin
    errors_o  = 0;
    results_o = 0;
    grants_o  = 0;
    denials_o = 0;
    rejects_o = 0;
  end

  // Results are checked before the request of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (id_map[w]) id_map[w] = '0;
      grants_due.delete();
    end else begin
      if (res_valid_i && res_ready_i) check_result();
      if (req_valid_i && req_ready_i) begin
        if (req_user_i[0] == REQ_ALLOC) grants_due.push_back(next_grant());
        else grants_due.push_back(release_id(req_data_i[ID_W-1:0]));
      end
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the station identifier allocator.
// ----------------------------------------------------------------------------
// A short directed run hits reuse of the lowest freed identifier and every
// kind of bad release. A mixed random run follows, then a long allocate-only
// run that packs the map well into its upper words, then a mixed run on the
// packed map. Both stream sides idle and stall at random, with calm stretches.
// ----------------------------------------------------------------------------
module tb;
  import aid_pkg::*;

  localparam int unsigned MAX_ID       = MAX_ID_DEF;
  localparam int unsigned BITMAP_WORDS = BITMAP_WORDS_DEF;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          MIXED_START  = 100;
  localparam int          FILL_ALLOCS  = 1600;
  localparam int          MIXED_FULL   = 130;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [10:0] release_id
  logic [0:0]  s_axis_tuser;   // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [10:0] granted_id
  logic [0:0]  m_axis_tuser;   // [0] ok

  int   errors, pending, results, grants, denials, rejects;
  int   cycle_cnt;
  int   req_cnt;
  logic calm;

  association_id_allocator_top #(
    .MAX_ID       (MAX_ID),
    .BITMAP_WORDS (BITMAP_WORDS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  aid_grant_checker #(
    .MAX_ID       (MAX_ID),
    .BITMAP_WORDS (BITMAP_WORDS)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_user_i  (s_axis_tuser),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .res_user_i  (m_axis_tuser),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results),
    .grants_o    (grants),
    .denials_o   (denials),
    .rejects_o   (rejects)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Releases favor the low, busy part of the map and the range edges
  function automatic logic [ID_W-1:0] pick_release_id();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return ID_W'($urandom_range(1, 96));
    if (r < 8) return ID_W'($urandom_range(0, 2047));
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ID_W'(MAX_ID);
      2:       return ID_W'(MAX_ID + 1);
      3:       return '1;
      4:       return ID_W'(WORD_BITS * $urandom_range(1, BITMAP_WORDS - 1));
      default: return ID_W'(WORD_BITS * $urandom_range(1, BITMAP_WORDS - 1) + 1);
    endcase
  endfunction

  // One request; valid stays high across back-to-back requests
  task automatic send_req(input logic kind, input logic [ID_W-1:0] id);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(16 - ID_W){1'b0}}, id};
    do @(posedge clk_i); while (!s_axis_tready);
    req_cnt++;
    calm = ((req_cnt / 128) % 4) == 3;
  endtask

  task automatic send_mixed(input int n, input int alloc_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < alloc_pct)
        send_req(REQ_ALLOC, ID_W'($urandom_range(0, 2047)));
      else
        send_req(REQ_RELEASE, pick_release_id());
    end
  endtask

  // Result side stalls
  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall == 0 && !calm && $urandom_range(0, 99) < 30) stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Cycle limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i) cycle_cnt++;
    $display("timeout after %0d cycles", cycle_cnt);
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_ALLOC;
    rst_ni        = 1'b0;
    req_cnt       = 0;
    calm          = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: grants, reuse of the lowest freed id, bad and free releases
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_RELEASE, ID_W'(2));
    send_req(REQ_ALLOC, '0);
    send_req(REQ_RELEASE, '0);
    send_req(REQ_RELEASE, ID_W'(MAX_ID + 1));
    send_req(REQ_RELEASE, '1);
    send_req(REQ_RELEASE, ID_W'(MAX_ID));
    send_req(REQ_RELEASE, ID_W'(1024));
    send_req(REQ_RELEASE, ID_W'(1));
    send_req(REQ_RELEASE, ID_W'(1));
    send_req(REQ_ALLOC, '1);
    send_req(REQ_ALLOC, ID_W'(1024));
    send_req(REQ_ALLOC, '0);
    send_req(REQ_RELEASE, ID_W'(3));
    send_req(REQ_RELEASE, ID_W'(33));
    send_req(REQ_ALLOC, ID_W'(MAX_ID));

    send_mixed(MIXED_START, 60);
    // Pack the map far up with allocates only
    for (int i = 0; i < FILL_ALLOCS; i++)
      send_req(REQ_ALLOC, ID_W'($urandom_range(0, 2047)));
    send_mixed(MIXED_FULL, 50);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d requests, %0d results: %0d grants, %0d allocates denied",
             req_cnt, results, grants, denials);
    $display("%0d releases rejected as out of range (MAX_ID %0d)",
             rejects, MAX_ID);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== association_id_allocator_top.f =====
rtl/aid_pkg.sv
rtl/aid_bitmap_ram.sv
rtl/aid_word_tracker.sv
rtl/association_id_allocator_top.sv
tb/sv/aid_grant_checker.sv
tb/sv/tb.sv
